### design/rmdf_pkg.sv
// ----------------------------------------------------------------------------
// rmdf_pkg: shared types and constants of the RSSI median deadband filter
// Field widths, register reset values, register codes and the sort link word.
// ----------------------------------------------------------------------------
`default_nettype none

package rmdf_pkg;

    localparam int WINDOW_DEF   = 6;
    localparam int CHANNELS_DEF = 4;

    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 9;
    localparam int DB_W     = 5;

    localparam logic signed [SAMPLE_W-1:0] FLOOR_RST    = -8'sd72;
    localparam logic [DB_W-1:0]            DEADBAND_RST = 5'd3;

    // register index as decoded from paddr[2]
    localparam logic REG_FLOOR    = 1'b0;
    localparam logic REG_DEADBAND = 1'b1;

    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] val;
    } link_t;

endpackage

`default_nettype wire

### design/rmdf_ram.sv
// ----------------------------------------------------------------------------
// rmdf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/rmdf_sort_cell.sv
// ----------------------------------------------------------------------------
// rmdf_sort_cell: one cell of the insertion sort chain
// Keeps the smallest word seen since clear and hands the larger one onward.
// ----------------------------------------------------------------------------
`default_nettype none

module rmdf_sort_cell (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  clear,
    input  wire rmdf_pkg::link_t                       din,
    output rmdf_pkg::link_t                            dout,
    output logic signed [rmdf_pkg::SAMPLE_W-1:0]       value
);
    import rmdf_pkg::*;

    link_t hold_reg, hold_next;
    link_t pass_reg, pass_next;

    always_comb begin
        hold_next     = hold_reg;
        pass_next     = din;
        pass_next.vld = 1'b0;
        if (clear) begin
            hold_next.vld = 1'b0;
        end else if (din.vld) begin
            if (!hold_reg.vld) begin
                hold_next = din;
            end else if (din.val < hold_reg.val) begin
                // keep the smaller word, push the old one down the chain
                hold_next.val = din.val;
                pass_next.vld = 1'b1;
                pass_next.val = hold_reg.val;
            end else begin
                pass_next.vld = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg.vld <= 1'b0;
            pass_reg.vld <= 1'b0;
        end else begin
            hold_reg <= hold_next;
            pass_reg <= pass_next;
        end
    end

    assign dout  = pass_reg;
    assign value = hold_reg.val;

endmodule

`default_nettype wire

### design/rssi_median_deadband_filter_top.sv
// ----------------------------------------------------------------------------
// rssi_median_deadband_filter_top: per-channel RSSI median filter with deadband
// Collects kept samples per channel, sorts each full window in a cell chain and
// moves the reported level only when the median leaves the deadband.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser carries the channel, s_tdata the RSSI sample and
//   the transmit power. Result stream m_*: one word per input word, with the
//   channel and window flag in m_tuser and the level and power in m_tdata.
//   Registers accept_floor (0x0) and deadband (0x4) sit on the APB port; write
//   them only while no word is in flight.
//   Sequence: a word that does not complete a window passes through the EVAL
//   and EMIT states, then its result loads into the output register and raises
//   m_tvalid; the next word is taken once the sequencer is back in IDLE. A word
//   that completes a window also passes through SORT, MED and UPD before EMIT:
//   the window is read from the sample RAM one entry a cycle into a chain of
//   WINDOW sort cells, which then settle there before the median is taken.
//   One word is in work at a time; the next is taken as soon as the previous
//   result sits in the output register, even while the receiver stalls. A
//   stalled result holds until m_tready, then the next result may load.
//   Reset clears the fill counts, seed flags, reported levels and both
//   registers to their defaults; the sample RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_median_deadband_filter_top #(
    parameter int WINDOW   = rmdf_pkg::WINDOW_DEF,
    parameter int CHANNELS = rmdf_pkg::CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rssi_sample, [15:8] tx_power
    input  wire logic [1:0]  s_tuser,   // [1:0] channel
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [8:0] level_half_dbm, [16:9] out_tx_power
    output logic [2:0]       m_tuser,   // [1:0] out_channel, [2] window_done
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rmdf_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FC_W   = $clog2(WINDOW + 1);
    localparam int CNT_W  = $clog2(2 * WINDOW + 1);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MED_LO = ((WINDOW % 2) == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);
    localparam int MED_HI = WINDOW / 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_SORT = 3'd2;
    localparam logic [2:0] ST_MED  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    // configuration registers
    logic signed [SAMPLE_W-1:0] floor_reg;
    logic [DB_W-1:0]            deadband_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg    <= FLOOR_RST;
            deadband_reg <= DEADBAND_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FLOOR:    floor_reg    <= pwdata[SAMPLE_W-1:0];
                REG_DEADBAND: deadband_reg <= pwdata[DB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FLOOR:    prdata = {{(32-SAMPLE_W){floor_reg[SAMPLE_W-1]}}, floor_reg};
            REG_DEADBAND: prdata = {{(32-DB_W){1'b0}}, deadband_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // per-channel state
    logic [FC_W-1:0]           fill_reg     [CHANNELS];
    logic                      seeded_reg   [CHANNELS];
    logic signed [LEVEL_W-1:0] held_reg     [CHANNELS];
    logic signed [LEVEL_W-1:0] reported_reg [CHANNELS];

    // captured word
    logic [2:0]                 state_reg;
    logic [CHAN_W-1:0]          ch_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0]        txp_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       rd_vld_reg;
    logic signed [LEVEL_W-1:0]  med_reg;

    logic              ch_ok;
    logic [CH_W-1:0]   ch_idx;
    logic              keep;
    logic [FC_W-1:0]   fill_inc;
    logic              full;
    logic [ADDR_W-1:0] base_addr;
    logic              rd_en;
    logic              chain_clear;

    assign ch_ok     = (5'(ch_reg) < 5'(CHANNELS));
    assign ch_idx    = CH_W'(ch_reg);
    assign keep      = ch_ok && (sample_reg != '0) && (sample_reg > floor_reg);
    assign fill_inc  = fill_reg[ch_idx] + FC_W'(1);
    assign full      = (fill_inc == FC_W'(WINDOW));
    assign base_addr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(WINDOW));
    assign rd_en     = (state_reg == ST_SORT) && (cnt_reg < CNT_W'(WINDOW));
    assign chain_clear = (state_reg == ST_EVAL) && keep && full;

    assign s_tready = (state_reg == ST_IDLE);

    // sample store
    logic [SAMPLE_W-1:0] ram_rdata;

    rmdf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    ((state_reg == ST_EVAL) && keep),
        .waddr (base_addr + ADDR_W'(fill_reg[ch_idx])),
        .wdata (sample_reg),
        .re    (rd_en),
        .raddr (base_addr + ADDR_W'(cnt_reg)),
        .rdata (ram_rdata)
    );

    // sort chain
    link_t                      link     [WINDOW];
    logic signed [SAMPLE_W-1:0] cell_val [WINDOW];

    assign link[0].vld = rd_vld_reg;
    assign link[0].val = ram_rdata;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i < WINDOW - 1) begin : g_mid
            rmdf_sort_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .clear   (chain_clear),
                .din     (link[i]),
                .dout    (link[i+1]),
                .value   (cell_val[i])
            );
        end else begin : g_last
            rmdf_sort_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .clear   (chain_clear),
                .din     (link[i]),
                .dout    (),
                .value   (cell_val[i])
            );
        end
    end

    // deadband test
    logic signed [LEVEL_W:0] diff;
    logic [LEVEL_W:0]        diff_abs;
    logic                    moved;

    assign diff     = {med_reg[LEVEL_W-1], med_reg}
                    - {held_reg[ch_idx][LEVEL_W-1], held_reg[ch_idx]};
    assign diff_abs = diff[LEVEL_W] ? (~diff + 1'b1) : diff;
    assign moved    = diff_abs > {{(LEVEL_W-DB_W){1'b0}}, deadband_reg, 1'b0};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c]     <= '0;
                seeded_reg[c]   <= 1'b0;
                reported_reg[c] <= '0;
            end
        end else begin
            rd_vld_reg <= rd_en;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (keep && full) begin
                        fill_reg[ch_idx] <= '0;
                        state_reg        <= ST_SORT;
                    end else begin
                        if (keep) begin
                            fill_reg[ch_idx] <= fill_inc;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SORT: begin
                    if (cnt_reg == CNT_W'(2 * WINDOW)) begin
                        state_reg <= ST_MED;
                    end
                end
                ST_MED: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (!seeded_reg[ch_idx]) begin
                        seeded_reg[ch_idx] <= 1'b1;
                    end else if (moved) begin
                        reported_reg[ch_idx] <= med_reg;
                    end else begin
                        reported_reg[ch_idx] <= held_reg[ch_idx];
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload of the word in work
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg     <= s_tuser;
            sample_reg <= s_tdata[7:0];
            txp_reg    <= s_tdata[15:8];
        end
        if (state_reg == ST_EVAL) begin
            done_reg <= keep && full;
            cnt_reg  <= '0;
        end else if (state_reg == ST_SORT) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (state_reg == ST_MED) begin
            med_reg <= LEVEL_W'(cell_val[MED_LO]) + LEVEL_W'(cell_val[MED_HI]);
        end
        if (state_reg == ST_UPD && (!seeded_reg[ch_idx] || moved)) begin
            held_reg[ch_idx] <= med_reg;
        end
    end

    // output register
    logic                      m_valid_reg;
    logic [CHAN_W-1:0]         m_ch_reg;
    logic signed [LEVEL_W-1:0] m_level_reg;
    logic [SAMPLE_W-1:0]       m_txp_reg;
    logic                      m_done_reg;
    logic                      m_load;

    assign m_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_ch_reg    <= ch_reg;
            m_level_reg <= ch_ok ? reported_reg[ch_idx] : '0;
            m_txp_reg   <= txp_reg;
            m_done_reg  <= done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_txp_reg, m_level_reg};
    assign m_tuser  = {m_done_reg, m_ch_reg};

endmodule

`default_nettype wire
